// ===== rtl/ims_pkg.sv =====
// shared types and constants for the isolation monitor sequencer
// no dependencies
package ims_pkg;

    typedef struct packed {
        logic               link_up;
        logic [16:0]        pack_centivolt;
        logic signed [23:0] sample_microvolt;
        logic               sample_ok;
    } in_t;

    typedef struct packed {
        logic        relay_pos_on;
        logic        relay_neg_on;
        logic [31:0] pos_riso_ohm;
        logic [31:0] neg_riso_ohm;
        logic        pos_low_iso;
        logic        neg_low_iso;
        logic        measurement_fault;
        logic [1:0]  cycle_phase;
    } out_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_POS   = 2'd1,
        PH_PAUSE = 2'd2,
        PH_NEG   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_PDIFF,
        S_PMUL,
        S_PDSET,
        S_PDIV,
        S_RCHK,
        S_RM1,
        S_RM2,
        S_RM3,
        S_RM4,
        S_RDIV,
        S_EMIT
    } seq_t;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_OHM = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIM  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACK  = 4'd5;

    localparam logic [15:0] RST_INTERVAL  = 16'd200;
    localparam logic [15:0] RST_SETTLE    = 16'd20;
    localparam logic [15:0] RST_PAUSE     = 16'd10;
    localparam logic [31:0] RST_FAULT_OHM = 32'd48000;
    localparam logic [7:0]  RST_FAIL_LIM  = 8'd10;
    localparam logic [16:0] RST_MIN_PACK  = 17'd1000;

    localparam logic [21:0] MID_UV   = 22'd2500000;
    localparam logic [23:0] K_NUM    = 24'd121;
    localparam logic [8:0]  K_DEN    = 9'd511;
    localparam logic [23:0] RCHAIN   = 24'd1210000;
    localparam logic [23:0] MEGA     = 24'd1000000;
    localparam logic [20:0] MEGA_V   = 21'd1000000;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 24;

endpackage

// ===== rtl/isolation_monitor_sequencer_top.sv =====
// isolation monitor measurement sequencer: phase timing, pole averaging,
// isolation resistance; depends on ims_pkg, ims_mul, ims_div
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_stall   | one 1 ms tick (ims_pkg::in_t)
//  out     | output    | out_valid/out_stall | one status result (ims_pkg::out_t)
//  cfg     | input     | cfg_valid/cfg_ready | register index and write data
//
// a tick without a sample goes straight to the output; a positive pole sample sums
// its window and divides for the pole mean, and a negative pole sample may then also
// work out both resistances on the one divider shared by the pole mean and both resistances
// reset clears all control state and loads the register defaults
// in_stall is high from an accepted tick until its result enters the output
// register; a stalled output holds the sequencer in its final state
module isolation_monitor_sequencer_top #(
    parameter int AVG_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ims_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ims_pkg::out_t                   out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ims_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import ims_pkg::*;

    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = 24 + FILL_W;
    localparam int DIFF_W = SUM_W + 2;
    localparam int DEN_W  = 9 + FILL_W;

    // configuration
    logic [15:0] interval_reg, settle_reg, pause_reg;
    logic [31:0] fault_ohm_reg;
    logic [7:0]  limit_reg;
    logic [16:0] min_pack_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= RST_INTERVAL;
            settle_reg    <= RST_SETTLE;
            pause_reg     <= RST_PAUSE;
            fault_ohm_reg <= RST_FAULT_OHM;
            limit_reg     <= RST_FAIL_LIM;
            min_pack_reg  <= RST_MIN_PACK;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INTERVAL:  interval_reg  <= cfg_data[15:0];
                CFG_SETTLE:    settle_reg    <= cfg_data[15:0];
                CFG_PAUSE:     pause_reg     <= cfg_data[15:0];
                CFG_FAULT_OHM: fault_ohm_reg <= cfg_data;
                CFG_FAIL_LIM:  limit_reg     <= cfg_data[7:0];
                CFG_MIN_PACK:  min_pack_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // state
    seq_t                     seq_reg, seq_next;
    phase_t                   phase_reg, phase_next;
    logic [15:0]              elapsed_reg, elapsed_next;
    logic [FILL_W-1:0]        pos_fill_reg, pos_fill_next, neg_fill_reg, neg_fill_next;
    logic [SLOT_W-1:0]        pos_slot_reg, pos_slot_next, neg_slot_reg, neg_slot_next;
    logic signed [20:0]       pos_mv_reg, pos_mv_next, neg_mv_reg, neg_mv_next;
    logic                     pos_valid_reg, pos_valid_next, neg_valid_reg, neg_valid_next;
    logic [31:0]              pos_riso_reg, pos_riso_next, neg_riso_reg, neg_riso_next;
    logic                     pos_ok_reg, pos_ok_next;
    logic [7:0]               failed_reg, failed_next;
    logic                     fault_reg, fault_next;
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg, out_next;

    // working registers
    logic                     side_reg, side_next;
    logic [SLOT_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIFF_W-1:0]        mag_reg, mag_next;
    logic                     pneg_reg, pneg_next;
    logic [16:0]              pack_reg, pack_next;
    logic [20:0]              c_reg, c_next;
    logic [41:0]              p1_reg, p1_next;
    logic [41:0]              lo_reg, lo_next;

    // sample windows
    logic signed [23:0]       pos_win_reg [AVG_DEPTH];
    logic signed [23:0]       neg_win_reg [AVG_DEPTH];
    logic                     win_we, win_side;
    logic [SLOT_W-1:0]        win_slot;

    // shared units
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_p;
    logic                     div_start, div_busy, div_done;
    logic [DIV_N_W-1:0]       div_n, div_q;
    logic [DIV_D_W-1:0]       div_d;

    ims_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    ims_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // helpers from stored state
    logic                     accept;
    logic                     run_ok;
    logic [15:0]              el_inc;
    logic [FILL_W-1:0]        cur_fill;
    logic signed [23:0]       win_rd;
    logic [20:0]              volt_mv;
    logic [20:0]              pm, nm, dmv;
    logic                     ratio_big;
    logic [DEN_W-1:0]         den;
    logic [DIFF_W-1:0]        mid;
    logic signed [DIFF_W-1:0] diff;
    logic signed [24:0]       qv, pv;
    logic signed [20:0]       pole_new;
    logic [31:0]              riso_new;
    logic signed [22:0]       cdiff;
    logic [22:0]              cneg;
    logic                     bad_sign;
    logic [63:0]              big;

    assign accept   = in_valid && !in_stall;
    assign run_ok   = in_data.link_up && (in_data.pack_centivolt >= min_pack_reg);
    assign el_inc   = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign cur_fill = side_reg ? neg_fill_reg : pos_fill_reg;
    assign win_rd   = side_reg ? neg_win_reg[idx_reg] : pos_win_reg[idx_reg];
    assign volt_mv  = 21'(pack_reg) * 21'd10;
    assign pm       = pos_mv_reg[20] ? 21'd0 : pos_mv_reg;
    assign nm       = neg_mv_reg[20] ? 21'(-neg_mv_reg) : 21'd0;
    assign dmv      = side_reg ? pm : nm;
    // dmv * 1e6 >= V, with V below 2^21
    assign ratio_big = (dmv >= 21'd2) || ((dmv == 21'd1) && (volt_mv <= MEGA_V));
    assign den      = DEN_W'(cur_fill) * DEN_W'(K_DEN);
    assign mid      = DIFF_W'(cur_fill) * DIFF_W'(MID_UV);
    assign diff     = $signed(mid) - DIFF_W'(sum_reg);
    assign bad_sign = pos_mv_reg[20] || (neg_mv_reg > 21'sd100) || (volt_mv == '0);
    assign cdiff    = $signed({2'b00, volt_mv}) - $signed({2'b00, pm}) - $signed({2'b00, nm});
    assign cneg     = 23'(-cdiff);
    assign big      = {mul_p[42:0], 21'b0} + 64'(lo_reg);

    // rounded pole voltage from the quotient, saturated to 21 bits signed; resistance saturated to 32 bits
    always_comb
    begin
        qv = $signed({4'b0000, div_q[20:0]});
        pv = pneg_reg ? 25'sd2500 - qv : 25'sd2500 + qv;
        if (div_q[63:21] != '0)
            pole_new = pneg_reg ? -21'sd1048576 : 21'sd1048575;
        else if (pv > 25'sd1048575)
            pole_new = 21'sd1048575;
        else if (pv < -25'sd1048576)
            pole_new = -21'sd1048576;
        else
            pole_new = 21'(pv);
        riso_new = (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
    end

    // next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    seq_next = S_EMIT;
                    if (run_ok && (phase_reg == PH_POS) && (el_inc >= settle_reg)
                        && in_data.sample_ok)
                        seq_next = S_SUM;
                    if (run_ok && (phase_reg == PH_NEG) && (el_inc >= settle_reg)
                        && in_data.sample_ok)
                        seq_next = S_SUM;
                end
            end
            S_SUM:
                if ((FILL_W'(idx_reg) + FILL_W'(1)) == cur_fill)
                    seq_next = S_PDIFF;
            S_PDIFF: seq_next = S_PMUL;
            S_PMUL:  seq_next = S_PDSET;
            S_PDSET: seq_next = S_PDIV;
            S_PDIV:
                if (div_done)
                    seq_next = side_reg ? S_RCHK : S_EMIT;
            S_RCHK:
            begin
                if (!pos_valid_reg || bad_sign)
                    seq_next = S_EMIT;
                else if (cdiff < 0 && (25'(cneg) * 25'd100 >= 25'(volt_mv)))
                    seq_next = S_EMIT;
                else
                    seq_next = S_RM1;
            end
            S_RM1: seq_next = S_RM2;
            S_RM2: seq_next = ratio_big ? S_RDIV : S_RM3;
            S_RM3: seq_next = S_RM4;
            S_RM4: seq_next = S_RDIV;
            S_RDIV:
                if (div_done)
                    seq_next = side_reg ? S_EMIT : S_RM1;
            S_EMIT:
                if (!out_valid_reg || !out_stall)
                    seq_next = S_IDLE;
            default: seq_next = S_IDLE;
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        pos_fill_next  = pos_fill_reg;
        neg_fill_next  = neg_fill_reg;
        pos_slot_next  = pos_slot_reg;
        neg_slot_next  = neg_slot_reg;
        pos_mv_next    = pos_mv_reg;
        neg_mv_next    = neg_mv_reg;
        pos_valid_next = pos_valid_reg;
        neg_valid_next = neg_valid_reg;
        pos_riso_next  = pos_riso_reg;
        neg_riso_next  = neg_riso_reg;
        pos_ok_next    = pos_ok_reg;
        failed_next    = failed_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        side_next      = side_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        mag_next       = mag_reg;
        pneg_next      = pneg_reg;
        pack_next      = pack_reg;
        c_next         = c_reg;
        p1_next        = p1_reg;
        lo_next        = lo_reg;
        win_we         = 1'b0;
        win_side       = 1'b0;
        win_slot       = pos_slot_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_n          = '0;
        div_d          = '0;

        unique case (seq_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pack_next = in_data.pack_centivolt;
                    idx_next  = '0;
                    sum_next  = '0;
                    if (!run_ok)
                    begin
                        phase_next     = PH_IDLE;
                        elapsed_next   = '0;
                        pos_fill_next  = '0;
                        neg_fill_next  = '0;
                        pos_slot_next  = '0;
                        neg_slot_next  = '0;
                        pos_mv_next    = '0;
                        neg_mv_next    = '0;
                        pos_valid_next = 1'b0;
                        neg_valid_next = 1'b0;
                        pos_riso_next  = '0;
                        neg_riso_next  = '0;
                        pos_ok_next    = 1'b0;
                        failed_next    = '0;
                        fault_next     = 1'b0;
                    end
                    else
                    begin
                        elapsed_next = el_inc;
                        unique case (phase_reg)
                            PH_IDLE:
                                if (el_inc >= interval_reg)
                                begin
                                    pos_ok_next  = 1'b0;
                                    phase_next   = PH_POS;
                                    elapsed_next = '0;
                                end
                            PH_POS:
                                if (el_inc >= settle_reg)
                                begin
                                    phase_next   = PH_PAUSE;
                                    elapsed_next = '0;
                                    side_next    = 1'b0;
                                    pos_ok_next  = in_data.sample_ok;
                                    if (in_data.sample_ok)
                                    begin
                                        win_we        = 1'b1;
                                        win_side      = 1'b0;
                                        win_slot      = pos_slot_reg;
                                        pos_slot_next = (pos_slot_reg == SLOT_W'(AVG_DEPTH - 1))
                                                        ? '0 : pos_slot_reg + 1'b1;
                                        if (pos_fill_reg != FILL_W'(AVG_DEPTH))
                                            pos_fill_next = pos_fill_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        pos_valid_next = 1'b0;
                                        pos_mv_next    = '0;
                                        pos_riso_next  = '0;
                                    end
                                end
                            PH_PAUSE:
                                if (el_inc >= pause_reg)
                                begin
                                    phase_next   = PH_NEG;
                                    elapsed_next = '0;
                                end
                            PH_NEG:
                                if (el_inc >= settle_reg)
                                begin
                                    phase_next    = PH_IDLE;
                                    elapsed_next  = '0;
                                    side_next     = 1'b1;
                                    pos_riso_next = '0;
                                    neg_riso_next = '0;
                                    // close the cycle: both samples good or count a failure
                                    if (pos_ok_reg && in_data.sample_ok)
                                    begin
                                        failed_next = '0;
                                        fault_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        failed_next = (failed_reg == 8'hFF)
                                                      ? failed_reg : failed_reg + 8'd1;
                                        fault_next  = failed_next >= limit_reg;
                                    end
                                    if (in_data.sample_ok)
                                    begin
                                        win_we        = 1'b1;
                                        win_side      = 1'b1;
                                        win_slot      = neg_slot_reg;
                                        neg_slot_next = (neg_slot_reg == SLOT_W'(AVG_DEPTH - 1))
                                                        ? '0 : neg_slot_reg + 1'b1;
                                        if (neg_fill_reg != FILL_W'(AVG_DEPTH))
                                            neg_fill_next = neg_fill_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        neg_valid_next = 1'b0;
                                        neg_mv_next    = '0;
                                    end
                                end
                            default: ;
                        endcase
                    end
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(win_rd);
                idx_next = idx_reg + 1'b1;
            end
            S_PDIFF:
            begin
                pneg_next = diff < 0;
                mag_next  = (diff < 0) ? DIFF_W'(-diff) : DIFF_W'(diff);
            end
            S_PMUL:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = K_NUM;
            end
            S_PDSET:
            begin
                div_start = 1'b1;
                div_n     = {mul_p[DIV_N_W-2:0], 1'b0} + 64'(den);
                div_d     = DIV_D_W'({den, 1'b0});
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    if (side_reg)
                    begin
                        neg_mv_next    = pole_new;
                        neg_valid_next = 1'b1;
                    end
                    else
                    begin
                        pos_mv_next    = pole_new;
                        pos_valid_next = 1'b1;
                    end
                end
            end
            S_RCHK:
            begin
                side_next = 1'b0;
                c_next    = (cdiff < 0) ? '0 : 21'(cdiff);
                if (pos_valid_reg)
                begin
                    if (bad_sign || (cdiff < 0 && (25'(cneg) * 25'd100 >= 25'(volt_mv))))
                    begin
                        pos_valid_next = 1'b0;
                        neg_valid_next = 1'b0;
                    end
                end
            end
            S_RM1:
            begin
                mul_a = MUL_A_W'(c_reg);
                mul_b = RCHAIN;
            end
            S_RM2:
            begin
                p1_next = mul_p[41:0];
                if (ratio_big)
                begin
                    div_start = 1'b1;
                    div_n     = {mul_p[DIV_N_W-2:0], 1'b0} + 64'(dmv);
                    div_d     = DIV_D_W'({dmv, 1'b0});
                end
                else
                begin
                    mul_a = MUL_A_W'(mul_p[20:0]);
                    mul_b = MEGA;
                end
            end
            S_RM3:
            begin
                lo_next = mul_p[41:0];
                mul_a   = MUL_A_W'(p1_reg[41:21]);
                mul_b   = MEGA;
            end
            S_RM4:
            begin
                div_start = 1'b1;
                div_n     = {big[62:0], 1'b0} + 64'(volt_mv);
                div_d     = DIV_D_W'({volt_mv, 1'b0});
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    if (side_reg)
                        neg_riso_next = riso_new;
                    else
                    begin
                        pos_riso_next = riso_new;
                        side_next     = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_next.relay_pos_on      = phase_reg == PH_POS;
                    out_next.relay_neg_on      = phase_reg == PH_NEG;
                    out_next.pos_riso_ohm      = pos_riso_reg;
                    out_next.neg_riso_ohm      = neg_riso_reg;
                    out_next.pos_low_iso       = pos_valid_reg && (pos_riso_reg < fault_ohm_reg);
                    out_next.neg_low_iso       = neg_valid_reg && (neg_riso_reg < fault_ohm_reg);
                    out_next.measurement_fault = fault_reg;
                    out_next.cycle_phase       = phase_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_IDLE;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            pos_fill_reg  <= '0;
            neg_fill_reg  <= '0;
            pos_slot_reg  <= '0;
            neg_slot_reg  <= '0;
            pos_mv_reg    <= '0;
            neg_mv_reg    <= '0;
            pos_valid_reg <= 1'b0;
            neg_valid_reg <= 1'b0;
            pos_riso_reg  <= '0;
            neg_riso_reg  <= '0;
            pos_ok_reg    <= 1'b0;
            failed_reg    <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            pos_fill_reg  <= pos_fill_next;
            neg_fill_reg  <= neg_fill_next;
            pos_slot_reg  <= pos_slot_next;
            neg_slot_reg  <= neg_slot_next;
            pos_mv_reg    <= pos_mv_next;
            neg_mv_reg    <= neg_mv_next;
            pos_valid_reg <= pos_valid_next;
            neg_valid_reg <= neg_valid_next;
            pos_riso_reg  <= pos_riso_next;
            neg_riso_reg  <= neg_riso_next;
            pos_ok_reg    <= pos_ok_next;
            failed_reg    <= failed_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        side_reg <= side_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        mag_reg  <= mag_next;
        pneg_reg <= pneg_next;
        pack_reg <= pack_next;
        c_reg    <= c_next;
        p1_reg   <= p1_next;
        lo_reg   <= lo_next;
        if (win_we && !win_side)
            pos_win_reg[win_slot] <= in_data.sample_microvolt;
        if (win_we && win_side)
            neg_win_reg[win_slot] <= in_data.sample_microvolt;
    end

    assign in_stall  = seq_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == S_IDLE |-> !div_busy) else $error("divider busy while sequencer idle");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_fill_reg <= FILL_W'(AVG_DEPTH)) && (neg_fill_reg <= FILL_W'(AVG_DEPTH)))
        else $error("window fill beyond depth");
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg == '0 |-> !fault_reg) else $error("fault without failed cycles");
    a_riso_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == S_IDLE && pos_riso_reg != '0) |-> pos_valid_reg)
        else $error("positive resistance kept on an invalid pole");

endmodule

// ===== rtl/ims_mul.sv =====
// shared unsigned multiplier with registered product
// depends on ims_pkg
module ims_mul (
    input  logic                          clk,
    input  logic [ims_pkg::MUL_A_W-1:0]   a,
    input  logic [ims_pkg::MUL_B_W-1:0]   b,
    output logic [ims_pkg::MUL_P_W-1:0]   prod
);
    import ims_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/ims_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on ims_pkg
module ims_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ims_pkg::DIV_N_W-1:0]   dividend,
    input  logic [ims_pkg::DIV_D_W-1:0]   divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ims_pkg::DIV_N_W-1:0]   quotient
);
    import ims_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_N_W);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? DIV_D_W'(trial - {1'b0, den_reg}) : DIV_D_W'(trial);
            quo_next  = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = cnt_reg != '0;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy) else $error("divider restarted while busy");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("divider done while still counting");
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy) else $error("divider did not start");

endmodule

// ===== test/ims_checker.sv =====
// status predictor and scoreboard for the isolation monitor sequencer
// watches the tick, status and register channels; depends on ims_pkg
module ims_checker
    import ims_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_t                  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_t                 out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   mismatch_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = 4;

    typedef struct {
        longint     win [WIN];
        int         fill;
        int         slot;
        longint     mv;
        bit         ok;
        longint     riso;
    } pole_rec_t;

    // register copy
    logic [15:0] interval_r;
    logic [15:0] settle_r;
    logic [15:0] pause_r;
    logic [31:0] fault_ohm_r;
    logic [7:0]  fail_lim_r;
    logic [16:0] min_pack_r;

    // sequencer copy
    phase_t      phase_r;
    int          elapsed_r;
    pole_rec_t   pos_r;
    pole_rec_t   neg_r;
    bit          pos_cycle_ok;
    bit          neg_cycle_ok;
    int          failed_r;
    bit          fault_r;

    out_t        expected_status_q [$];

    function automatic pole_rec_t cleared_pole();
        pole_rec_t p;
        foreach (p.win[i]) p.win[i] = 0;
        p.fill = 0;
        p.slot = 0;
        p.mv   = 0;
        p.ok   = 1'b0;
        p.riso = 0;
        return p;
    endfunction

    task automatic clear_all();
        pos_r        = cleared_pole();
        neg_r        = cleared_pole();
        pos_cycle_ok = 1'b0;
        neg_cycle_ok = 1'b0;
        failed_r     = 0;
        fault_r      = 1'b0;
    endtask

    // window mean to pole millivolts, round half away from zero
    function automatic bit take_sample(inout pole_rec_t p, input in_t t);
        longint sum;
        longint num;
        longint den;
        longint q;
        longint v;
        if (!t.sample_ok) begin
            p.ok   = 1'b0;
            p.mv   = 0;
            p.riso = 0;
            return 1'b0;
        end
        p.win[p.slot] = longint'({{40{t.sample_microvolt[23]}}, t.sample_microvolt});
        p.slot = (p.slot + 1) % WIN;
        if (p.fill < WIN)
            p.fill++;
        sum = 0;
        for (int i = 0; i < p.fill; i++)
            sum += p.win[i];
        num = (64'sd2500000 * p.fill - sum) * 121;
        den = 511 * p.fill;
        if (num >= 0)
            q = (2 * num + den) / (2 * den);
        else
            q = -((-2 * num + den) / (2 * den));
        v = 2500 + q;
        if (v > 1048575)
            v = 1048575;
        if (v < -1048576)
            v = -1048576;
        p.mv = v;
        p.ok = 1'b1;
        return 1'b1;
    endfunction

    function automatic longint ratio_round(longint unsigned n, longint unsigned d);
        longint unsigned q;
        q = (2 * n + d) / (2 * d);
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(q);
    endfunction

    function automatic longint one_riso(longint unsigned c, longint unsigned dv,
                                        longint unsigned v);
        if (dv * 1000000 >= v)
            return ratio_round(1210000 * c, dv);
        return ratio_round(64'd1210000000000 * c, v);
    endfunction

    task automatic refresh_riso(logic [16:0] pack);
        longint v;
        longint pm;
        longint nm;
        longint c;
        pos_r.riso = 0;
        neg_r.riso = 0;
        if (!pos_r.ok || !neg_r.ok || pack < min_pack_r)
            return;
        v  = longint'(pack) * 10;
        pm = pos_r.mv;
        nm = (neg_r.mv < 0) ? -neg_r.mv : 0;
        if (pm < 0 || neg_r.mv > 100 || v == 0) begin
            pos_r.ok = 1'b0;
            neg_r.ok = 1'b0;
            return;
        end
        c = v - pm - nm;
        if (c < 0) begin
            // small overshoot is treated as a dead short
            if (100 * (-c) < v) begin
                c = 0;
            end
            else begin
                pos_r.ok = 1'b0;
                neg_r.ok = 1'b0;
                return;
            end
        end
        pos_r.riso = one_riso(c, nm, v);
        neg_r.riso = one_riso(c, pm, v);
    endtask

    task automatic tick_status_predict(in_t t);
        out_t e;
        if (!t.link_up || t.pack_centivolt < min_pack_r) begin
            clear_all();
            phase_r   = PH_IDLE;
            elapsed_r = 0;
        end
        else begin
            if (elapsed_r < 65535)
                elapsed_r++;
            case (phase_r)
                PH_IDLE:
                    if (elapsed_r >= interval_r) begin
                        pos_cycle_ok = 1'b0;
                        neg_cycle_ok = 1'b0;
                        phase_r      = PH_POS;
                        elapsed_r    = 0;
                    end
                PH_POS:
                    if (elapsed_r >= settle_r) begin
                        pos_cycle_ok = take_sample(pos_r, t);
                        phase_r      = PH_PAUSE;
                        elapsed_r    = 0;
                    end
                PH_PAUSE:
                    if (elapsed_r >= pause_r) begin
                        phase_r   = PH_NEG;
                        elapsed_r = 0;
                    end
                default:
                    if (elapsed_r >= settle_r) begin
                        neg_cycle_ok = take_sample(neg_r, t);
                        refresh_riso(t.pack_centivolt);
                        if (pos_cycle_ok && neg_cycle_ok) begin
                            failed_r = 0;
                            fault_r  = 1'b0;
                        end
                        else begin
                            if (failed_r < 255)
                                failed_r++;
                            fault_r = failed_r >= fail_lim_r;
                        end
                        phase_r   = PH_IDLE;
                        elapsed_r = 0;
                    end
            endcase
        end
        e.relay_pos_on      = phase_r == PH_POS;
        e.relay_neg_on      = phase_r == PH_NEG;
        e.pos_riso_ohm      = pos_r.riso[31:0];
        e.neg_riso_ohm      = neg_r.riso[31:0];
        e.pos_low_iso       = pos_r.ok && (pos_r.riso[31:0] < fault_ohm_r);
        e.neg_low_iso       = neg_r.ok && (neg_r.riso[31:0] < fault_ohm_r);
        e.measurement_fault = fault_r;
        e.cycle_phase       = phase_r;
        expected_status_q.push_back(e);
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic compare_status(out_t a);
        out_t e;
        if (expected_status_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: status beat with nothing expected, got %h", $time, a);
            return;
        end
        e = expected_status_q.pop_front();
        check_field("relay_pos_on", e.relay_pos_on, a.relay_pos_on);
        check_field("relay_neg_on", e.relay_neg_on, a.relay_neg_on);
        check_field("pos_riso_ohm", e.pos_riso_ohm, a.pos_riso_ohm);
        check_field("neg_riso_ohm", e.neg_riso_ohm, a.neg_riso_ohm);
        check_field("pos_low_iso", e.pos_low_iso, a.pos_low_iso);
        check_field("neg_low_iso", e.neg_low_iso, a.neg_low_iso);
        check_field("measurement_fault", e.measurement_fault, a.measurement_fault);
        check_field("cycle_phase", e.cycle_phase, a.cycle_phase);
    endtask

    initial
    begin
        interval_r     = RST_INTERVAL;
        settle_r       = RST_SETTLE;
        pause_r        = RST_PAUSE;
        fault_ohm_r    = RST_FAULT_OHM;
        fail_lim_r     = RST_FAIL_LIM;
        min_pack_r     = RST_MIN_PACK;
        phase_r        = PH_IDLE;
        elapsed_r      = 0;
        mismatch_count = 0;
        clear_all();
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INTERVAL:  interval_r  = cfg_data[15:0];
                    CFG_SETTLE:    settle_r    = cfg_data[15:0];
                    CFG_PAUSE:     pause_r     = cfg_data[15:0];
                    CFG_FAULT_OHM: fault_ohm_r = cfg_data;
                    CFG_FAIL_LIM:  fail_lim_r  = cfg_data[7:0];
                    CFG_MIN_PACK:  min_pack_r  = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                tick_status_predict(in_data);
            if (out_valid && !out_stall)
                compare_status(out_data);
        end
    end

    assign pending_count = expected_status_q.size();

endmodule

// ===== test/tb_top.sv =====
// testbench top for the isolation monitor sequencer: clock, reset, tick and
// register stimulus, verdict; depends on ims_pkg, ims_checker and the rtl
module tb_top;
    import ims_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_WAIT = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int mismatch_count;
    int pending_count;
    int ticks_sent;
    int status_seen;
    int cycles;
    int stall_hold;
    bit calm;
    phase_t last_phase;
    logic [16:0] min_pack_now;

    isolation_monitor_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ims_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver side stall pattern
    always @(posedge clk)
    begin
        if (stall_hold == 0) begin
            out_stall  <= !calm && ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
        else begin
            stall_hold <= stall_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) begin
            status_seen <= status_seen + 1;
            last_phase  <= phase_t'(out_data.cycle_phase);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("isolation_monitor_sequencer_top regression: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(in_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= t;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (status_seen != ticks_sent)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic load_setting(int interval, int settle, int pause, logic [31:0] ohm,
                                int lim, int min_pack);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_PAUSE, pause);
        write_reg(CFG_FAULT_OHM, ohm);
        write_reg(CFG_FAIL_LIM, lim);
        write_reg(CFG_MIN_PACK, min_pack);
        min_pack_now = min_pack;
    endtask

    // converter reading that rebuilds to the given pole millivolts
    function automatic logic signed [23:0] sample_for(longint mv);
        longint uv;
        uv = 2500000 - ((mv - 2500) * 511) / 121;
        if (uv > 6144000)
            uv = 6144000;
        if (uv < -6144000)
            uv = -6144000;
        return uv[23:0];
    endfunction

    function automatic in_t random_tick();
        in_t t;
        int r;
        longint v;
        r = $urandom_range(0, 99);
        t.link_up          = 1'b1;
        t.pack_centivolt   = $urandom_range(min_pack_now, 100000);
        t.sample_ok        = $urandom_range(0, 19) != 0;
        v = longint'(t.pack_centivolt) * 10;
        if (last_phase == PH_IDLE && $urandom_range(0, 1))
            t.sample_microvolt = sample_for($urandom_range(0, v));
        else if (last_phase == PH_POS)
            t.sample_microvolt = sample_for($urandom_range(0, v));
        else
            t.sample_microvolt = sample_for(-longint'($urandom_range(0, v)));
        if (r < 4)
            t.link_up = 1'b0;
        else if (r < 7)
            t.pack_centivolt = $urandom_range(0, 100000);
        else if (r < 12)
            t.sample_microvolt = $urandom_range(0, 12288000) - 6144000;
        else if (r < 14)
            t.sample_microvolt = sample_for($urandom_range(0, 2 * v) + 100);
        return t;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
            send_tick(random_tick());
    endtask

    initial
    begin
        in_t t;
        logic signed [23:0] edge_uv [6];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cycles       = 0;
        stall_hold   = 0;
        calm         = 1'b0;
        ticks_sent   = 0;
        status_seen  = 0;
        last_phase   = PH_IDLE;
        min_pack_now = RST_MIN_PACK;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few ticks under reset defaults, then fast phases with no floor
        for (int i = 0; i < 3; i++)
        begin
            t = '{1'b1, 17'd50000, 24'sd0, 1'b1};
            send_tick(t);
        end
        drain();
        load_setting(1, 1, 1, 32'd48000, 1, 0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);

        // directed: converter and pack extremes, failed reads, link loss
        edge_uv = '{24'sd6144000, -24'sd6144000, 24'sd0, 24'sd2500000,
                    sample_for(100), sample_for(-400000)};
        for (int i = 0; i < 22; i++)
        begin
            t.link_up          = (i != 17);
            t.pack_centivolt   = (i < 4) ? 17'd0 : (i % 3 == 0) ? 17'd100000 : 17'd60000;
            t.sample_microvolt = edge_uv[i % 6];
            t.sample_ok        = (i != 9) && (i != 14);
            send_tick(t);
        end
        drain();

        calm = 1'b1;
        random_run(200);
        drain();
        calm = 1'b0;
        load_setting(2, 3, 1, 32'd2000000, 3, 500);
        random_run(280);
        drain();
        load_setting(1, 1, 1, 32'd0, 1, 0);
        random_run(260);
        drain();
        load_setting(1, 2, 2, 32'hFFFF_FFFF, 255, 100000);
        random_run(180);
        drain();
        load_setting(65535, 65535, 65535, 32'd100000, 2, 1000);
        random_run(30);
        drain();
        load_setting(3, 1, 4, 32'd100000, 2, 20000);
        random_run(300);
        drain();
        load_setting(1, 1, 1, 32'd48000, 10, 1000);
        random_run(280);
        drain();

        $display("sent %0d ticks over seven register settings, %0d status beats checked",
                 ticks_sent, status_seen);
        $display("covered phase timing extremes, window averaging, riso limits and faults");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("isolation_monitor_sequencer_top regression: pass");
        end
        else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, pending_count);
            $display("isolation_monitor_sequencer_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ims_pkg.sv
rtl/ims_mul.sv
rtl/ims_div.sv
rtl/isolation_monitor_sequencer_top.sv
test/ims_checker.sv
test/tb_top.sv
